// File: sv/refraction_vector_unit_defines.svh
// Assertion macros shared by the refraction vector unit.
`ifndef REFRACTION_VECTOR_UNIT_DEFINES_SVH
`define REFRACTION_VECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define RVU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define RVU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers reset itself.
`define RVU_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/rvu_pkg.sv
// Types and constants of the refraction vector unit.
package rvu_pkg;

    // One input transaction: direction and normal in Q2.14, index ratio in Q3.13.
    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic        [15:0] eta_ratio;
    } t_rvu_in;

    // One output transaction: refracted direction in Q6.14 and the saturation flag.
    typedef struct packed {
        logic signed [19:0] out_x;
        logic signed [19:0] out_y;
        logic signed [19:0] out_z;
        logic               clipped;
    } t_rvu_out;

    // Output bounds.
    localparam logic signed [19:0] OUT_MAX = 20'sh7FFFF;
    localparam logic signed [19:0] OUT_MIN = 20'sh80000;

    // Cosine upper clamp, 1.0 in Q.28.
    localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

    // Square root steps: one result bit per stage, 30 result bits.
    localparam int SQ_STEPS = 30;

    // Stages ahead of the root, the root itself, and the two final stages.
    localparam int PRE_STAGES = 8;
    localparam int NUM_STAGES = PRE_STAGES + SQ_STEPS + 2;

endpackage

// File: sv/refraction_vector_unit.sv
// Refraction vector unit: pipelined Snell refraction of a ray direction about a normal.
//
//  Channel | Direction | Handshake                        | Payload
//  --------+-----------+----------------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_stall          | i_in_data  (t_rvu_in)
//  out     | output    | o_out_valid / i_out_stall        | o_out_data (t_rvu_out)
//
//  One transaction enters per cycle while the pipeline is not held (see below).
//  The pipeline is the 30-stage square root, one result bit per stage, plus
//  ten arithmetic stages around it (dot product, cosine, scaling, squares, output).
//  The whole pipeline advances together: it holds only while the output register is
//  full and stalled, and then o_in_stall is raised. Reset is synchronous and clears
//  the valid bits of every stage; the data registers are not reset.
`include "refraction_vector_unit_defines.svh"

module refraction_vector_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rvu_pkg::t_rvu_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rvu_pkg::t_rvu_out o_out_data
);
    import rvu_pkg::*;

    // Pipeline control.
    logic                  w_adv;
    logic [NUM_STAGES-1:0] r_v;

    // Stage 1: component products of the dot product.
    logic signed [31:0] r1_dn  [3];
    logic signed [15:0] r1_d   [3];
    logic signed [15:0] r1_n   [3];
    logic        [15:0] r1_eta;

    // Stage 2: clamped cosine.
    logic signed [33:0] n_c;
    logic signed [33:0] r2_c;
    logic signed [15:0] r2_d   [3];
    logic signed [15:0] r2_n   [3];
    logic        [15:0] r2_eta;

    // Stage 3: cosine times normal.
    logic signed [49:0] r3_cn  [3];
    logic signed [15:0] r3_d   [3];
    logic signed [15:0] r3_n   [3];
    logic        [15:0] r3_eta;

    // Stage 4: direction plus scaled normal, rounded to Q.28.
    logic signed [50:0] n_t    [3];
    logic signed [35:0] r4_u   [3];
    logic signed [15:0] r4_n   [3];
    logic        [15:0] r4_eta;

    // Stage 5: scaled by the index ratio.
    logic signed [52:0] r5_ue  [3];
    logic signed [15:0] r5_n   [3];

    // Stage 6: perpendicular part, rounded to Q.20.
    logic signed [52:0] n_ue_r [3];
    logic signed [30:0] r6_p   [3];
    logic signed [15:0] r6_n   [3];

    // Stage 7: squares of the perpendicular part.
    logic signed [61:0] n_pp   [3];
    logic        [59:0] r7_pp  [3];
    logic signed [30:0] r7_p   [3];
    logic signed [15:0] r7_n   [3];

    // Stage 8: magnitude of one minus the squared length.
    logic        [61:0] n_len;
    logic signed [62:0] n_diff;
    logic signed [62:0] n_abs;
    logic        [59:0] r8_a;
    logic signed [30:0] r8_p   [3];
    logic signed [15:0] r8_n   [3];

    // Square root stages.
    logic        [59:0] w_sq_a_in   [SQ_STEPS];
    logic        [60:0] w_sq_res_in [SQ_STEPS];
    logic signed [30:0] w_sq_p_in   [SQ_STEPS][3];
    logic signed [15:0] w_sq_n_in   [SQ_STEPS][3];
    logic        [59:0] r_sq_a      [SQ_STEPS];
    logic        [60:0] r_sq_res    [SQ_STEPS];
    logic signed [30:0] r_sq_p      [SQ_STEPS][3];
    logic signed [15:0] r_sq_n      [SQ_STEPS][3];
    logic        [29:0] w_root;

    // Root times normal.
    logic signed [46:0] r9_rn  [3];
    logic signed [30:0] r9_p   [3];

    // Output stage.
    logic signed [47:0] n_o    [3];
    logic signed [27:0] n_q    [3];
    logic signed [19:0] n_sat  [3];
    logic        [2:0]  n_clip;
    t_rvu_out           r_out;

    // Checking helper: the flag is clear or some component sits at a bound.
    logic               w_clip_ok;

    // The pipeline moves unless a finished result is held by the consumer.
    assign w_adv       = !(r_v[NUM_STAGES-1] && i_out_stall);
    assign o_in_stall  = !w_adv;
    assign o_out_valid = r_v[NUM_STAGES-1];
    assign o_out_data  = r_out;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NUM_STAGES-2:0], i_in_valid};
        end
    end

    // Stage 1 register.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_d[0] <= i_in_data.dir_x;
            r1_d[1] <= i_in_data.dir_y;
            r1_d[2] <= i_in_data.dir_z;
            r1_n[0] <= i_in_data.norm_x;
            r1_n[1] <= i_in_data.norm_y;
            r1_n[2] <= i_in_data.norm_z;
            r1_dn[0] <= i_in_data.dir_x * i_in_data.norm_x;
            r1_dn[1] <= i_in_data.dir_y * i_in_data.norm_y;
            r1_dn[2] <= i_in_data.dir_z * i_in_data.norm_z;
            r1_eta   <= i_in_data.eta_ratio;
        end
    end

    // Cosine is the negated dot product, clamped to at most one.
    always_comb begin
        n_c = -(34'(r1_dn[0]) + 34'(r1_dn[1]) + 34'(r1_dn[2]));
        if (n_c > ONE_Q28) begin
            n_c = ONE_Q28;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_c   <= n_c;
            r2_d   <= r1_d;
            r2_n   <= r1_n;
            r2_eta <= r1_eta;
        end
    end

    // Stage 3 register: cosine times each normal component.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r3_cn[i] <= r2_c * r2_n[i];
            end
            r3_d   <= r2_d;
            r3_n   <= r2_n;
            r3_eta <= r2_eta;
        end
    end

    // Direction in Q.42 plus the scaled normal, rounded half up to Q.28.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i] = (51'(r3_d[i]) <<< 28) + 51'(r3_cn[i]) + 51'sd8192;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r4_u[i] <= $signed(n_t[i][49:14]);
            end
            r4_n   <= r3_n;
            r4_eta <= r3_eta;
        end
    end

    // Stage 5 register: times the index ratio.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r5_ue[i] <= r4_u[i] * $signed({1'b0, r4_eta});
            end
            r5_n <= r4_n;
        end
    end

    // Round the perpendicular part half up to Q.20.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ue_r[i] = r5_ue[i] + 53'sd1048576;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r6_p[i] <= $signed(n_ue_r[i][51:21]);
            end
            r6_n <= r5_n;
        end
    end

    // Squares of the perpendicular components.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pp[i] = r6_p[i] * r6_p[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r7_pp[i] <= n_pp[i][59:0];
            end
            r7_p <= r6_p;
            r7_n <= r6_n;
        end
    end

    // Squared length against one in Q.40; the root takes its magnitude.
    always_comb begin
        n_len  = 62'(r7_pp[0]) + 62'(r7_pp[1]) + 62'(r7_pp[2]);
        n_diff = (63'sd1 <<< 40) - $signed({1'b0, n_len});
        n_abs  = n_diff[62] ? -n_diff : n_diff;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_a <= n_abs[59:0];
            r8_p <= r7_p;
            r8_n <= r7_n;
        end
    end

    // Stage inputs of the square root: the first takes the magnitude with a zero root.
    always_comb begin
        w_sq_a_in[0]   = r8_a;
        w_sq_res_in[0] = '0;
        w_sq_p_in[0]   = r8_p;
        w_sq_n_in[0]   = r8_n;
        for (int j = 1; j < SQ_STEPS; j++) begin
            w_sq_a_in[j]   = r_sq_a[j-1];
            w_sq_res_in[j] = r_sq_res[j-1];
            w_sq_p_in[j]   = r_sq_p[j-1];
            w_sq_n_in[j]   = r_sq_n[j-1];
        end
    end

    // Digit-by-digit square root, one result bit per stage, highest first.
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
        localparam logic [60:0] SQ_BIT = 61'd1 << (2 * (SQ_STEPS - 1 - j));
        logic [60:0] w_trial;
        logic        w_take;

        assign w_trial = w_sq_res_in[j] + SQ_BIT;
        assign w_take  = {1'b0, w_sq_a_in[j]} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (w_take) begin
                    r_sq_a[j]   <= w_sq_a_in[j] - w_trial[59:0];
                    r_sq_res[j] <= (w_sq_res_in[j] >> 1) + SQ_BIT;
                end else begin
                    r_sq_a[j]   <= w_sq_a_in[j];
                    r_sq_res[j] <= w_sq_res_in[j] >> 1;
                end
                r_sq_p[j] <= w_sq_p_in[j];
                r_sq_n[j] <= w_sq_n_in[j];
            end
        end
    end

    assign w_root = r_sq_res[SQ_STEPS-1][29:0];

    // Stage register: root times each normal component.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r9_rn[i] <= $signed({1'b0, w_root}) * r_sq_n[SQ_STEPS-1][i];
            end
            r9_p <= r_sq_p[SQ_STEPS-1];
        end
    end

    // Perpendicular minus parallel part, rounded half up to Q.14, then saturated.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_o[i] = (48'(r9_p[i]) <<< 14) - 48'(r9_rn[i]) + 48'sd524288;
            n_q[i] = $signed(n_o[i][47:20]);
            if (n_q[i] > 28'(OUT_MAX)) begin
                n_sat[i]  = OUT_MAX;
                n_clip[i] = 1'b1;
            end else if (n_q[i] < 28'(OUT_MIN)) begin
                n_sat[i]  = OUT_MIN;
                n_clip[i] = 1'b1;
            end else begin
                n_sat[i]  = n_q[i][19:0];
                n_clip[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.out_x   <= n_sat[0];
            r_out.out_y   <= n_sat[1];
            r_out.out_z   <= n_sat[2];
            r_out.clipped <= |n_clip;
        end
    end

    // The flag is only allowed when some component sits at a bound.
    assign w_clip_ok = !o_out_data.clipped ||
                       o_out_data.out_x == OUT_MAX || o_out_data.out_x == OUT_MIN ||
                       o_out_data.out_y == OUT_MAX || o_out_data.out_y == OUT_MIN ||
                       o_out_data.out_z == OUT_MAX || o_out_data.out_z == OUT_MIN;

    // A flagged result has at least one component at a bound.
    `RVU_ASSERT_NOW(a_clip_at_bound, i_clk, i_rst_n, o_out_valid, w_clip_ok, "stray clip flag")

    // A held pipeline neither drops nor gains transactions.
    `RVU_ASSERT_NEXT(a_hold_keeps_valids, i_clk, i_rst_n, !w_adv, $stable(r_v), "valids moved")

    // Reset empties every stage.
    `RVU_ASSERT_NEXT_ALWAYS(a_reset_empties, i_clk, !i_rst_n, r_v == '0, "not empty after reset")

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the refraction vector unit, with a bit-exact fixed-point predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rvu_pkg::*;

    // Fixed-point ones for building stimulus.
    localparam int ONE_Q14 = 16384;
    localparam int ONE_Q13 = 8192;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_vec3;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    t_rvu_in  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_rvu_out out_data;

    // Results predicted for accepted rays, oldest first.
    t_rvu_out refracted_q [$];
    int       failures = 0;
    int       src_idle_pct = 0;
    int       snk_idle_pct = 0;
    int       hold_request = 0;
    int       hold_left = 0;

    refraction_vector_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // floor((x + 2^(k-1)) / 2^k), that is rounding half toward plus infinity.
    function automatic longint round_shift(input longint x, input int unsigned k);
        return (x + (longint'(1) << (k - 1))) >>> k;
    endfunction

    // Integer square root, rounded down.
    function automatic longint unsigned floor_sqrt(input longint unsigned a);
        longint unsigned res;
        longint unsigned probe;
        res = 0;
        probe = longint'(1) << 62;
        while (probe > a)
            probe = probe >> 2;
        while (probe != 0) begin
            if (a >= res + probe) begin
                a = a - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    // Refracted direction of one ray, exactly as the datapath rounds and saturates.
    function automatic t_rvu_out refract_ray(input t_rvu_in ray);
        longint             dv [3];
        longint             nv [3];
        longint             perp [3];
        longint             eta;
        longint             dot;
        longint             cosine;
        longint             len_sq;
        longint             gap;
        longint             outer;
        longint             q;
        longint unsigned    root;
        logic signed [19:0] comp [3];
        logic               clip;
        t_rvu_out           res;
        dv[0] = longint'($signed(ray.dir_x));
        dv[1] = longint'($signed(ray.dir_y));
        dv[2] = longint'($signed(ray.dir_z));
        nv[0] = longint'($signed(ray.norm_x));
        nv[1] = longint'($signed(ray.norm_y));
        nv[2] = longint'($signed(ray.norm_z));
        eta = longint'(ray.eta_ratio);

        // Cosine of incidence, clamped above at one but not below.
        dot = 0;
        for (int i = 0; i < 3; i++)
            dot = dot + dv[i] * nv[i];
        cosine = -dot;
        if (cosine > longint'(ONE_Q28))
            cosine = longint'(ONE_Q28);

        // Perpendicular part and its squared length.
        len_sq = 0;
        for (int i = 0; i < 3; i++) begin
            perp[i] = round_shift(round_shift(dv[i] * (longint'(1) << 28) + cosine * nv[i], 14)
                                  * eta, 21);
            len_sq = len_sq + perp[i] * perp[i];
        end

        // Parallel magnitude from the absolute value, so total internal reflection passes.
        gap = (longint'(1) << 40) - len_sq;
        if (gap < 0)
            gap = -gap;
        root = floor_sqrt(longint'(gap));

        // Sum of both parts, rounded to Q6.14 and saturated.
        clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            outer = perp[i] * (longint'(1) << 14) - longint'(root) * nv[i];
            q = round_shift(outer, 20);
            if (q > longint'(OUT_MAX)) begin
                q = longint'(OUT_MAX);
                clip = 1'b1;
            end else if (q < longint'(OUT_MIN)) begin
                q = longint'(OUT_MIN);
                clip = 1'b1;
            end
            comp[i] = q[19:0];
        end
        res.out_x = comp[0];
        res.out_y = comp[1];
        res.out_z = comp[2];
        res.clipped = clip;
        return res;
    endfunction

    function automatic t_rvu_in make_ray(input int dx, input int dy, input int dz,
                                         input int nx, input int ny, input int nz,
                                         input int eta);
        t_rvu_in ray;
        ray.dir_x = 16'(dx);
        ray.dir_y = 16'(dy);
        ray.dir_z = 16'(dz);
        ray.norm_x = 16'(nx);
        ray.norm_y = 16'(ny);
        ray.norm_z = 16'(nz);
        ray.eta_ratio = 16'(eta);
        return ray;
    endfunction

    function automatic real rand_signed_unit();
        return (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
    endfunction

    function automatic logic signed [15:0] to_q14(input real r);
        return 16'($rtoi(r * 16384.0 + ((r < 0.0) ? -0.5 : 0.5)));
    endfunction

    // Random direction of unit length in Q2.14.
    function automatic t_vec3 random_unit_dir();
        real   vx;
        real   vy;
        real   vz;
        real   len;
        t_vec3 v;
        do begin
            vx = rand_signed_unit();
            vy = rand_signed_unit();
            vz = rand_signed_unit();
            len = $sqrt(vx * vx + vy * vy + vz * vz);
        end while (len < 0.05);
        v.x = to_q14(vx / len);
        v.y = to_q14(vy / len);
        v.z = to_q14(vz / len);
        return v;
    endfunction

    function automatic int jitter();
        return int'($urandom_range(0, 16)) - 8;
    endfunction

    // Mostly physical hits, some odd ratios, near anti-parallel pairs, and raw noise.
    function automatic t_rvu_in random_ray();
        t_vec3   d;
        t_vec3   n;
        int      kind;
        int      dot;
        t_rvu_in ray;
        kind = $urandom_range(0, 99);
        d = random_unit_dir();
        n = random_unit_dir();
        ray.eta_ratio = 16'($urandom_range(4096, 20480));
        if (kind < 70) begin
            // Normal faces the incoming ray.
            dot = int'(d.x) * int'(n.x) + int'(d.y) * int'(n.y) + int'(d.z) * int'(n.z);
            if (dot > 0) begin
                n.x = -n.x;
                n.y = -n.y;
                n.z = -n.z;
            end
            if (kind >= 60)
                ray.eta_ratio = 16'($urandom());
        end else if (kind < 82) begin
            // Head-on hits with slightly long vectors push the cosine past one.
            n.x = 16'(-d.x + jitter());
            n.y = 16'(-d.y + jitter());
            n.z = 16'(-d.z + jitter());
            d.x = 16'(d.x + jitter());
            d.y = 16'(d.y + jitter());
            d.z = 16'(d.z + jitter());
        end
        ray.dir_x = d.x;
        ray.dir_y = d.y;
        ray.dir_z = d.z;
        ray.norm_x = n.x;
        ray.norm_y = n.y;
        ray.norm_z = n.z;
        if (kind >= 82) begin
            ray.dir_x = 16'($urandom());
            ray.dir_y = 16'($urandom());
            ray.dir_z = 16'($urandom());
            ray.norm_x = 16'($urandom());
            ray.norm_y = 16'($urandom());
            ray.norm_z = 16'($urandom());
            ray.eta_ratio = 16'($urandom());
        end
        return ray;
    endfunction

    // Offer one ray, with random idle cycles ahead of it, and hold it until accepted.
    task automatic send_ray(input t_rvu_in ray);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= ray;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Predict every accepted input transaction.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            refracted_q = {refracted_q, refract_ray(in_data)};
    end

    // Receiver stall: a requested hold-off first, random stalls otherwise.
    always @(negedge clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
        end
    end

    // Compare each accepted output transaction with the oldest prediction.
    always @(posedge clk) begin : check_results
        t_rvu_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (refracted_q.size() == 0) begin
                failures = failures + 1;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: x=%0d y=%0d z=%0d clipped=%0b",
                             out_data.out_x, out_data.out_y, out_data.out_z,
                             out_data.clipped);
            end else begin
                want = refracted_q.pop_front();
                if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
                    out_data.out_z !== want.out_z || out_data.clipped !== want.clipped) begin
                    failures = failures + 1;
                    if (failures <= MAX_REPORTS)
                        $display("result mismatch: expected x=%0d y=%0d z=%0d clipped=%0b,",
                                 want.out_x, want.out_y, want.out_z, want.clipped,
                                 " got x=%0d y=%0d z=%0d clipped=%0b",
                                 out_data.out_x, out_data.out_y, out_data.out_z,
                                 out_data.clipped);
                end
            end
        end
    end

    // Full-scale field values, where the outputs saturate both ways.
    task automatic test_field_extremes();
        send_ray(make_ray(0, 0, 0, 0, 0, 0, 0));
        send_ray(make_ray(32767, 32767, 32767, 32767, 32767, 32767, 65535));
        send_ray(make_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
        send_ray(make_ray(32767, -32768, 32767, -32768, 32767, -32768, 65535));
        send_ray(make_ray(-32768, 32767, -32768, 32767, -32768, 32767, 0));
        send_ray(make_ray(32767, 32767, 32767, 0, 0, 0, 65535));
        send_ray(make_ray(-32768, 0, 32767, 32767, 0, -32768, 1));
    endtask

    // Physical cases: normal and oblique incidence, grazing, clamp and total reflection.
    task automatic test_special_cases();
        send_ray(make_ray(0, 0, -ONE_Q14, 0, 0, ONE_Q14, ONE_Q13));
        send_ray(make_ray(0, 0, -ONE_Q14, 0, 0, ONE_Q14, 0));
        // Over-long direction pushes the cosine above one.
        send_ray(make_ray(0, 0, -32768, 0, 0, ONE_Q14, ONE_Q13));
        // Ray leaving through the surface gives a negative cosine, not clamped.
        send_ray(make_ray(0, 0, ONE_Q14, 0, 0, ONE_Q14, ONE_Q13));
        // Forty-five degrees into a denser and into a thinner medium.
        send_ray(make_ray(11585, 0, -11585, 0, 0, ONE_Q14, 5461));
        send_ray(make_ray(11585, 0, -11585, 0, 0, ONE_Q14, 12288));
        // Total internal reflection at a steep angle and large ratio.
        send_ray(make_ray(0, 15000, -6590, 0, 0, ONE_Q14, 20480));
        send_ray(make_ray(ONE_Q14, 0, 0, 0, 0, ONE_Q14, ONE_Q13));
        send_ray(make_ray(0, -9459, -13377, 0, 0, ONE_Q14, 10923));
        send_ray(make_ray(-9459, 13377, 0, 0, -ONE_Q14, 0, 6144));
    endtask

    task automatic test_random_rays(input int count, input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (count)
            send_ray(random_ray());
    endtask

    // Long receiver hold-off while rays keep coming, so the pipeline fills and stalls.
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        hold_request = 3 * NUM_STAGES + 30;
        repeat (120)
            send_ray(random_ray());
    endtask

    initial begin
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        src_idle_pct = 13;
        snk_idle_pct = 57;
        test_field_extremes();
        test_special_cases();
        test_random_rays(450, 13, 57);
        test_random_rays(450, 57, 13);
        test_random_rays(330, 0, 0);
        test_backpressure();

        @(negedge clk);
        in_valid <= 1'b0;
        while (refracted_q.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES + 20)
            @(posedge clk);

        if (failures == 0 && refracted_q.size() == 0)
            $display("[refraction_vector_unit] OK");
        else
            $display("[refraction_vector_unit] ERROR");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("[refraction_vector_unit] ERROR");
        $finish;
    end

endmodule
